/* src/agc_pkg.sv */
// Shared types and constants of the anagram group classifier.
`timescale 1ns / 1ps
package agc_pkg;
  localparam int AlphaBins = 26;
  localparam int CntW      = 6;
  localparam int MaxCnt    = 63;
  localparam int MaxGroups = 64;
  localparam int GrpW      = $clog2(MaxGroups);
  localparam int GcntW     = $clog2(MaxGroups + 1);
  localparam int MemW      = 8;
  localparam int MaxMembers = 255;
  localparam int LetW      = 5;

  typedef enum logic [1:0] {
    FUNC_LETTER = 2'd0,
    FUNC_LAST   = 2'd1,
    FUNC_EMPTY  = 2'd2,
    FUNC_CLEAR  = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_RES
  } state_e;

  typedef logic [AlphaBins-1:0][CntW-1:0] hist_t;

  typedef struct packed {
    logic cmp_en;
    logic load;
    logic inc;
  } cell_ctrl_t;
endpackage

/* src/agc_hist.sv */
// Per-word letter histogram with saturating bins.
`timescale 1ns / 1ps
module agc_hist (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     add_i,
  input  logic [agc_pkg::LetW-1:0] letter_i,
  input  logic                     clear_i,
  output agc_pkg::hist_t           hist_o,
  output logic                     sat_o
);
  import agc_pkg::*;

  hist_t hist_q, hist_d;
  logic  sat_q, sat_d;

  always_comb begin
    hist_d = hist_q;
    sat_d  = sat_q;
    if (clear_i) begin
      hist_d = '0;
      sat_d  = 1'b0;
    end else if (add_i) begin
      for (int b = 0; b < AlphaBins; b++) begin
        if (letter_i == LetW'(b)) begin
          if (hist_q[b] >= CntW'(MaxCnt)) begin
            sat_d = 1'b1;
          end else begin
            hist_d[b] = hist_q[b] + CntW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q <= '0;
      sat_q  <= 1'b0;
    end else begin
      hist_q <= hist_d;
      sat_q  <= sat_d;
    end
  end

  assign hist_o = hist_q;
  assign sat_o  = sat_q;
endmodule

/* src/agc_cell.sv */
// One group cell: stored signature, member count, compare and first-match chain.
`timescale 1ns / 1ps
module agc_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  agc_pkg::cell_ctrl_t      ctrl_i,
  input  logic                     in_use_i,
  input  logic                     sel_i,
  input  agc_pkg::hist_t           hist_i,
  input  logic                     prior_i,
  output logic                     prior_o,
  output logic                     first_o,
  output logic [agc_pkg::MemW-1:0] size_o
);
  import agc_pkg::*;

  hist_t            sig_q;
  logic [MemW-1:0]  size_q;
  logic             match_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctrl_i.cmp_en) begin
      match_q <= in_use_i && (sig_q == hist_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load && sel_i) begin
      sig_q  <= hist_i;
      size_q <= MemW'(1);
    end else if (ctrl_i.inc && first_o && size_q < MemW'(MaxMembers)) begin
      size_q <= size_q + MemW'(1);
    end
  end

  assign first_o = match_q && !prior_i;
  assign prior_o = match_q || prior_i;
  assign size_o  = size_q;
endmodule

/* src/anagram_group_classifier_core.sv */
// Top level of the anagram group classifier.
// A word-ending request passes the compare state, then the result state, which registers
// the result into the output register once the output is free. Letter and clear requests
// are taken while idle; a word end holds the input off through the compare in every group
// cell, then the first-match chain and table update; a stalled output holds it longer.
// Reset empties the group table, the histogram and the output register.
`timescale 1ns / 1ps
module anagram_group_classifier_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // letter[4:0], zero pad
  input  logic [1:0]  s_axis_tuser,  // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // group_index[5:0], new_group[6], member_index[14:7],
                                     // group_count[21:15], table_full[22], word_too_long[23]
);
  import agc_pkg::*;

  state_e state_q, state_d;
  logic   accept;
  func_e  func;
  logic   hist_clear, sat;
  hist_t  hist;
  cell_ctrl_t ctrl;
  logic [GcntW-1:0] count_q, count_d;
  logic [MaxGroups:0] chain;
  logic [MaxGroups-1:0] first;
  logic [MaxGroups-1:0][MemW-1:0] sizes;
  logic [GrpW-1:0] hit_idx, res_idx;
  logic [MemW-1:0] hit_size;
  logic found, can_open, out_free, res_fire;
  logic        out_valid_q;
  logic [23:0] out_q;

  assign func     = func_e'(s_axis_tuser);
  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid_q || m_axis_tready;
  assign res_fire = (state_q == ST_RES) && out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept && (func == FUNC_LAST || func == FUNC_EMPTY)) state_d = ST_CMP;
      ST_CMP:  state_d = ST_RES;
      ST_RES:  if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    ctrl.cmp_en   = (state_q == ST_CMP);
    ctrl.inc      = res_fire && found;
    ctrl.load     = res_fire && !found && can_open;
    hist_clear    = res_fire || (accept && func == FUNC_CLEAR);
  end

  agc_hist u_hist (
    .clk_i, .rst_ni,
    .add_i   (accept && (func == FUNC_LETTER || func == FUNC_LAST)),
    .letter_i(s_axis_tdata[LetW-1:0]),
    .clear_i (hist_clear),
    .hist_o  (hist),
    .sat_o   (sat)
  );

  assign chain[0] = 1'b0;
  for (genvar g = 0; g < MaxGroups; g++) begin : g_cell
    agc_cell u_cell (
      .clk_i, .rst_ni,
      .ctrl_i  (ctrl),
      .in_use_i(count_q > GcntW'(g)),
      .sel_i   (count_q[GrpW-1:0] == GrpW'(g)),
      .hist_i  (hist),
      .prior_i (chain[g]),
      .prior_o (chain[g+1]),
      .first_o (first[g]),
      .size_o  (sizes[g])
    );
  end

  always_comb begin
    hit_idx  = '0;
    hit_size = '0;
    for (int g = 0; g < MaxGroups; g++) begin
      hit_idx  = hit_idx  | (first[g] ? GrpW'(g) : '0);
      hit_size = hit_size | (first[g] ? sizes[g] : '0);
    end
  end

  assign found    = chain[MaxGroups];
  assign can_open = count_q < GcntW'(MaxGroups);
  assign res_idx  = found ? hit_idx : (can_open ? count_q[GrpW-1:0] : '0);

  always_comb begin
    count_d = count_q;
    if (accept && func == FUNC_CLEAR) begin
      count_d = '0;
    end else if (ctrl.load) begin
      count_d = count_q + GcntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (res_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_fire) begin
      out_q <= {sat, !found && !can_open, count_d, found ? hit_size : MemW'(0),
                !found && can_open, res_idx};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= GcntW'(MaxGroups)) else $error("group count overflow");
  a_one_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first)) else $error("several first matches");
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[22]) |-> (m_axis_tdata[21:15] == 7'(MaxGroups)
      && !m_axis_tdata[6])) else $error("table full with free slot");
endmodule
